>>> src/psnr_pkg.sv
package psnr_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_MIN_HEIGHT   = 3'd0;
  localparam logic [2:0] REG_FLOOR_SLOPE  = 3'd1;
  localparam logic [2:0] REG_MAX_HEIGHT   = 3'd2;
  localparam logic [2:0] REG_HALF_FOV     = 3'd3;
  localparam logic [2:0] REG_SECTOR_WIDTH = 3'd4;
  localparam logic [2:0] REG_SECTOR_COUNT = 3'd5;

  // item kinds
  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_DUMP  = 2'd2;

  localparam int ITER_W     = 5;
  localparam int SQRT_STEPS = 24;  // 48-bit radicand, two bits per step
  localparam int DIV_STEPS  = 16;  // 16-bit dividend, one bit per step
  localparam int CW         = 36;  // CORDIC x/y width
  localparam int AW         = 24;  // angle accumulator width, 2^-20 rad

  localparam logic [23:0] NO_RANGE  = 24'hFFFFFF;
  localparam logic [23:0] MAX_RANGE = 24'hFFFFFE;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_X,
    S_SQ_Y,
    S_SUM,
    S_ITER,
    S_FLOOR,
    S_CHECK,
    S_DIV,
    S_CLAMP,
    S_RD,
    S_UPD,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  // atan(2^-i) in 2^-20 rad, rounded
  function automatic logic [19:0] atan_fine(input logic [ITER_W-1:0] i);
    logic [19:0] v;
    begin
      case (i)
        5'd0:  v = 20'd823550;
        5'd1:  v = 20'd486170;
        5'd2:  v = 20'd256879;
        5'd3:  v = 20'd130396;
        5'd4:  v = 20'd65451;
        5'd5:  v = 20'd32757;
        5'd6:  v = 20'd16383;
        5'd7:  v = 20'd8192;
        5'd8:  v = 20'd4096;
        5'd9:  v = 20'd2048;
        5'd10: v = 20'd1024;
        5'd11: v = 20'd512;
        5'd12: v = 20'd256;
        5'd13: v = 20'd128;
        5'd14: v = 20'd64;
        5'd15: v = 20'd32;
        5'd16: v = 20'd16;
        5'd17: v = 20'd8;
        5'd18: v = 20'd4;
        5'd19: v = 20'd2;
        5'd20: v = 20'd1;
        5'd21: v = 20'd1;
        default: v = 20'd0;
      endcase
      return v;
    end
  endfunction

endpackage

>>> src/psnr_ram.sv
module psnr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/polar_sector_nearest_range_top.sv
// Polar sector nearest-range binning. Each point beat (tuser = kind 0) is tested for
// x > 0, z below max_height and z at or above a floor that rises with planar range;
// kept points get a bearing from CORDIC vectoring and land in one of the sectors in
// use across +-half_fov, and the sector keeps the smallest range seen. A clear
// beat (kind 1) empties all sectors; a dump beat (kind 2) streams one result beat
// per sector in use, in index order, tlast on the final one, tuser = hit.
// A point occupies the block (s_tready low) through the shared sqrt/CORDIC
// iteration loop and the bit-serial sector divider, with a shared 25x25 multiplier
// and a read-modify-write of the sector RAM around them. A point with x <= 0 or too
// high is dropped at once; one that fails the height floor or field of view is
// dropped at the check after the iteration loop. A dump reads each sector and then
// presents its beat, waiting on m_tready. Config writes are taken at any time.
module polar_sector_nearest_range_top
  import psnr_pkg::*;
#(
  parameter int MAX_SECTORS  = 64,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // x_coord[23:0], y_coord[47:24], z_coord[71:48]
  input  logic [1:0]  s_tuser,   // kind
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // sector[5:0], nearest_range[29:6], zero pad
  output logic        m_tuser,   // hit
  output logic        m_tlast
);

  localparam int IDX_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
  localparam int CNT_W = $clog2(MAX_SECTORS + 1);

  // configuration registers
  logic [22:0]        min_height;
  logic [15:0]        floor_slope;
  logic signed [23:0] max_height;
  logic [14:0]        half_fov;
  logic [14:0]        sector_width;
  logic [6:0]         sector_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_height   <= 23'd128;
      floor_slope  <= 16'd11796;
      max_height   <= 24'sd1024;
      half_fov     <= 15'd8579;
      sector_width <= 15'd572;
      sector_count <= 7'd30;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MIN_HEIGHT:   min_height   <= cfg_data[22:0];
        REG_FLOOR_SLOPE:  floor_slope  <= cfg_data[15:0];
        REG_MAX_HEIGHT:   max_height   <= $signed(cfg_data);
        REG_HALF_FOV:     half_fov     <= cfg_data[14:0];
        REG_SECTOR_WIDTH: sector_width <= cfg_data[14:0];
        REG_SECTOR_COUNT: sector_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // sectors in use, clamped to 1..MAX_SECTORS
  logic [CNT_W-1:0] n_used;
  logic [CNT_W-1:0] last_cnt;
  logic [IDX_W-1:0] last_idx;
  logic [14:0]      sw_eff;

  always_comb begin
    if (sector_count == 7'd0) begin
      n_used = CNT_W'(1);
    end else if (int'(sector_count) > MAX_SECTORS) begin
      n_used = CNT_W'(MAX_SECTORS);
    end else begin
      n_used = CNT_W'(sector_count);
    end
    last_cnt = CNT_W'(n_used - CNT_W'(1));
    last_idx = last_cnt[IDX_W-1:0];
    sw_eff   = (sector_width == 15'd0) ? 15'd1 : sector_width;
  end

  // input fields
  logic signed [23:0] x_in, y_in, z_in;
  assign x_in = $signed(s_tdata[23:0]);
  assign y_in = $signed(s_tdata[47:24]);
  assign z_in = $signed(s_tdata[71:48]);

  state_t state, state_next;

  logic signed [23:0] x, y, z;
  logic [ITER_W-1:0]  iter;

  // shared multiplier, registered product
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] mul_p;

  // sqrt
  logic [47:0] sq_sum;
  logic [47:0] rad;
  logic [26:0] rem;
  logic [23:0] root;
  logic [23:0] r;
  logic [23:0] r_sat;
  logic [26:0] rem_sh;
  logic [26:0] trial;
  logic        sq_take;

  // CORDIC
  logic signed [CW-1:0] cx, cy;
  logic signed [AW-1:0] ang;
  logic signed [CW-1:0] dx, dy;
  logic signed [AW-1:0] atan_s;

  // height and angle checks
  logic [25:0]          floor_z;
  logic                 height_ok;
  logic signed [AW-1:0] hf_s;
  logic signed [AW-1:0] off;
  logic                 fov_ok;

  // divider
  logic [15:0] dvd, quot, drem;
  logic [15:0] drem_sh;
  logic        d_take;

  logic [IDX_W-1:0]      sect;
  logic [MAX_SECTORS-1:0] valid;
  logic                  hit_r;

  logic        ram_we, ram_re;
  logic [23:0] ram_rdata;
  logic        upd_take;

  logic        in_fire, out_fire;
  logic        iter_done, div_done;

  assign in_fire   = s_tvalid && s_tready;
  assign out_fire  = m_tvalid && m_tready;
  assign iter_done = (iter == ITER_W'(SQRT_STEPS - 1));
  assign div_done  = (iter == ITER_W'(DIV_STEPS - 1));

  // range as it leaves the sqrt loop, before it is registered
  assign r_sat = (root > MAX_RANGE) ? MAX_RANGE : root;

  // operand select for the shared multiplier
  always_comb begin
    case (state)
      S_SQ_X: begin
        mul_a = 25'(x);
        mul_b = 25'(x);
      end
      S_SQ_Y: begin
        mul_a = 25'(y);
        mul_b = 25'(y);
      end
      S_FLOOR: begin
        mul_a = $signed({1'b0, r_sat});
        mul_b = $signed({9'd0, floor_slope});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // one sqrt step: two radicand bits in, one root bit out
  always_comb begin
    rem_sh  = {rem[24:0], rad[47:46]};
    trial   = {1'b0, root, 2'b01};
    sq_take = (rem_sh >= trial);
  end

  // one CORDIC step with floor shifts
  always_comb begin
    dx     = cy >>> iter;
    dy     = cx >>> iter;
    atan_s = $signed({4'd0, atan_fine(iter)});
  end

  always_comb begin
    floor_z   = 26'(min_height) + 26'(mul_p[40:16]);
    height_ok = (27'(z) >= $signed({1'b0, floor_z}));
    hf_s      = $signed({2'd0, half_fov, 7'd0});
    fov_ok    = (ang >= -hf_s) && (ang <= hf_s);
    off       = ang + hf_s;
  end

  // one restoring divide step
  always_comb begin
    drem_sh = {drem[14:0], dvd[15]};
    d_take  = (drem_sh >= {1'b0, sw_eff});
  end

  assign upd_take = !valid[sect] || (r < ram_rdata);

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          x    <= x_in;
          y    <= y_in;
          z    <= z_in;
          sect <= '0;
        end
      end
      S_SQ_Y: begin
        sq_sum <= 48'(mul_p);
      end
      S_SUM: begin
        rad  <= sq_sum + 48'(mul_p);
        rem  <= '0;
        root <= '0;
        cx   <= CW'(x) <<< 8;
        cy   <= CW'(y) <<< 8;
        ang  <= '0;
        iter <= '0;
      end
      S_ITER: begin
        rad <= rad << 2;
        if (sq_take) begin
          rem  <= 27'(rem_sh - trial);
          root <= {root[22:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[22:0], 1'b0};
        end
        if (32'(iter) < CORDIC_STEPS) begin
          if (cy >= 0) begin
            cx  <= cx + dx;
            cy  <= cy - dy;
            ang <= ang + atan_s;
          end else begin
            cx  <= cx - dx;
            cy  <= cy + dy;
            ang <= ang - atan_s;
          end
        end
        iter <= ITER_W'(iter + 1'b1);
      end
      S_FLOOR: begin
        r <= r_sat;
      end
      S_CHECK: begin
        dvd  <= off[22:7];
        drem <= '0;
        quot <= '0;
        iter <= '0;
      end
      S_DIV: begin
        dvd  <= dvd << 1;
        drem <= d_take ? 16'(drem_sh - {1'b0, sw_eff}) : drem_sh;
        quot <= {quot[14:0], d_take};
        iter <= ITER_W'(iter + 1'b1);
      end
      S_CLAMP: begin
        sect <= (32'(quot) >= 32'(n_used)) ? last_idx : quot[IDX_W-1:0];
      end
      S_DUMP_RD: begin
        hit_r <= valid[sect];
      end
      S_DUMP_OUT: begin
        if (out_fire && sect != last_idx) begin
          sect <= IDX_W'(sect + 1'b1);
        end
      end
      default: ;
    endcase
  end

  // sector valid bits: an entry not valid reads as no range
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (state == S_IDLE && in_fire && s_tuser == KIND_CLEAR) begin
      valid <= '0;
    end else if (ram_we) begin
      valid[sect] <= 1'b1;
    end
  end

  assign ram_re = (state == S_RD) || (state == S_DUMP_RD);
  assign ram_we = (state == S_UPD) && upd_take;

  psnr_ram #(
    .WIDTH (24),
    .DEPTH (MAX_SECTORS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sect),
    .wdata (r),
    .re    (ram_re),
    .raddr (sect),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (in_fire) begin
          case (s_tuser)
            KIND_POINT: begin
              if (x_in > 24'sd0 && z_in < max_height) begin
                state_next = S_SQ_X;
              end
            end
            KIND_DUMP: state_next = S_DUMP_RD;
            default: ;
          endcase
        end
      end
      S_SQ_X:  state_next = S_SQ_Y;
      S_SQ_Y:  state_next = S_SUM;
      S_SUM:   state_next = S_ITER;
      S_ITER: begin
        if (iter_done) begin
          state_next = S_FLOOR;
        end
      end
      S_FLOOR: state_next = S_CHECK;
      S_CHECK: begin
        state_next = (height_ok && fov_ok) ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: state_next = S_RD;
      S_RD:    state_next = S_UPD;
      S_UPD:   state_next = S_IDLE;
      S_DUMP_RD: state_next = S_DUMP_OUT;
      S_DUMP_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = (sect == last_idx) ? S_IDLE : S_DUMP_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign m_tdata = {2'b00, (hit_r ? ram_rdata : NO_RANGE), 6'(sect)};
  assign m_tuser = hit_r;
  assign m_tlast = (sect == last_idx);

endmodule

>>> bench/tb_polar_sector_nearest_range_top.sv
`timescale 1ns / 1ps

module tb_polar_sector_nearest_range_top
  import psnr_pkg::*;
();

  localparam int SLOTS  = 64;
  localparam int SETTLE = 64;      // idle margin after draining, so a point still in flight can finish
  localparam int LIMIT  = 300000;

  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [5:0]  sector;
    logic [23:0] nearest;
    logic        hit;
    logic        last;
  } sector_report_t;

  typedef enum int {Z_SPREAD, Z_AT_FLOOR, Z_BELOW_FLOOR, Z_AT_CEILING} height_pick_t;

  class range_board;
    longint min_h, incline, max_h, half_fov, sector_width, sector_count;
    logic [23:0] nearest [SLOTS];
    sector_report_t awaited [$];
    int errors;
    int shown;

    function new();
      min_h = 128;
      incline = 11796;
      max_h = 1024;
      half_fov = 8579;
      sector_width = 572;
      sector_count = 30;
      errors = 0;
      shown = 0;
      clear_all();
    endfunction

    function void clear_all();
      foreach (nearest[i]) nearest[i] = NO_RANGE;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        REG_MIN_HEIGHT:   min_h = val[22:0];
        REG_FLOOR_SLOPE:  incline = val[15:0];
        REG_MAX_HEIGHT:   max_h = longint'($signed(val));
        REG_HALF_FOV:     half_fov = val[14:0];
        REG_SECTOR_WIDTH: sector_width = val[14:0];
        REG_SECTOR_COUNT: sector_count = val[6:0];
        default: ;
      endcase
    endfunction

    function int used_count();
      if (sector_count == 0) return 1;
      if (sector_count > SLOTS) return SLOTS;
      return int'(sector_count);
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, probe;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
        if (v >= res + probe) begin
          v -= res + probe;
          res = (res >> 1) + probe;
        end else begin
          res >>= 1;
        end
        probe >>= 2;
      end
      return res;
    endfunction

    function longint plane_range(longint x, longint y);
      longint r;
      r = longint'(root(longint'(x * x + y * y)));
      if (r > longint'(MAX_RANGE)) r = longint'(MAX_RANGE);
      return r;
    endfunction

    function longint floor_at(longint x, longint y);
      return min_h + ((plane_range(x, y) * incline) >> 16);
    endfunction

    function longint atan_step(int i);
      case (i)
        0: return 823550;
        1: return 486170;
        2: return 256879;
        3: return 130396;
        4: return 65451;
        5: return 32757;
        6: return 16383;
        7: return 8192;
        8: return 4096;
        9: return 2048;
        10: return 1024;
        11: return 512;
        12: return 256;
        13: return 128;
        14: return 64;
        15: return 32;
        default: return 0;
      endcase
    endfunction

    // vectoring CORDIC, angle in 2^-20 rad; >>> on longint floors
    function longint bearing(longint x, longint y);
      longint cx, cy, ang, dx, dy;
      cx = x * 256;
      cy = y * 256;
      ang = 0;
      for (int i = 0; i < 16; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx += dx;
          cy -= dy;
          ang += atan_step(i);
        end else begin
          cx -= dx;
          cy += dy;
          ang -= atan_step(i);
        end
      end
      return ang;
    endfunction

    function void bin_point(longint x, longint y, longint z);
      longint r, ang, hf, sw, slot;
      if (x <= 0 || z >= max_h) return;
      r = plane_range(x, y);
      if (z < floor_at(x, y)) return;
      ang = bearing(x, y);
      hf = half_fov * 128;
      sw = (sector_width == 0 ? 1 : sector_width) * 128;
      if (ang < -hf || ang > hf) return;
      slot = (ang + hf) / sw;
      // bearing right on the upper edge lands in the last sector in use
      if (slot >= used_count()) slot = used_count() - 1;
      if (r < longint'(nearest[slot])) nearest[slot] = 24'(r);
    endfunction

    function void note(logic [1:0] kind, logic [23:0] x, logic [23:0] y, logic [23:0] z);
      sector_report_t e;
      int n;
      n = used_count();
      case (kind)
        KIND_POINT:
          bin_point(longint'($signed(x)), longint'($signed(y)), longint'($signed(z)));
        KIND_CLEAR: clear_all();
        KIND_DUMP: begin
          for (int k = 0; k < n; k++) begin
            e.sector = 6'(k);
            e.nearest = nearest[k];
            e.hit = (nearest[k] != NO_RANGE);
            e.last = (k == n - 1);
            awaited.insert(awaited.size(), e);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what, longint want, longint got);
      errors++;
      if (shown < 30) begin
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        shown++;
      end
    endtask

    task check(logic [5:0] sector, logic [23:0] nr, logic hit, logic last);
      sector_report_t e;
      if (awaited.size() == 0) begin
        report("unexpected result beat, sector", -1, sector);
      end else begin
        e = awaited.pop_front();
        if (sector !== e.sector) report("sector", e.sector, sector);
        if (nr !== e.nearest) report("nearest_range", e.nearest, nr);
        if (hit !== e.hit) report("hit", e.hit, hit);
        if (last !== e.last) report("last", e.last, last);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [23:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;   // x_coord[23:0], y_coord[47:24], z_coord[71:48]
  logic [1:0]  s_tuser = '0;   // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // sector[5:0], nearest_range[29:6], zero pad
  logic        m_tuser;        // hit
  logic        m_tlast;

  range_board sb;
  int cycle_count = 0;
  int burst_left = 0;
  bit idle_on = 1'b1;

  polar_sector_nearest_range_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // sink: always ready, coin-flip stalls, or one beat in four, rotating
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check(m_tdata[5:0], m_tdata[29:6], m_tuser, m_tlast);
    case ((cycle_count / 300) % 3)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= (cycle_count % 4 == 0);
    endcase
  end

  task automatic send(input logic [1:0] kind, input logic [23:0] x, input logic [23:0] y,
                      input logic [23:0] z);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note(kind, x, y, z);
  endtask

  task automatic send_bare(input logic [1:0] kind);
    send(kind, 24'($urandom), 24'($urandom), 24'($urandom));
  endtask

  // point at a bearing (1/8192 rad) and distance (1/256 m), height picked against the floor
  task automatic aimed_point(input int ang, input int reach, input height_pick_t pick);
    real a;
    longint x, y, z, fl;
    a = ang / 8192.0;
    x = $rtoi(reach * $cos(a));
    y = $rtoi(reach * $sin(a));
    fl = sb.floor_at(x, y);
    case (pick)
      Z_AT_FLOOR:    z = fl;
      Z_BELOW_FLOOR: z = fl - 1;
      Z_AT_CEILING:  z = sb.max_h;
      default: begin
        if (fl < sb.max_h) z = fl + $urandom_range(0, int'(sb.max_h - 1 - fl));
        else z = longint'($signed(24'($urandom)));
      end
    endcase
    if (z > 8388607) z = 8388607;
    if (z < -8388608) z = -8388608;
    send(KIND_POINT, 24'(x), 24'(y), 24'(z));
  endtask

  task automatic random_item();
    int roll, span, reach, hroll;
    height_pick_t pick;
    roll = $urandom_range(0, 99);
    span = int'(sb.half_fov) * 9 / 8 + 4;
    if (roll < 4) begin
      send_bare(KIND_CLEAR);
    end else if (roll < 14) begin
      send_bare(KIND_DUMP);
    end else if (roll < 17) begin
      send_bare(KIND_SPARE);
    end else if (roll < 32) begin
      send_bare(KIND_POINT);
    end else begin
      reach = ($urandom_range(0, 9) == 0) ? $urandom_range(12800, 8000000)
                                          : $urandom_range(8, 12800);
      hroll = $urandom_range(0, 9);
      pick = (hroll == 0) ? Z_BELOW_FLOOR : (hroll == 1) ? Z_AT_CEILING :
             (hroll == 2) ? Z_AT_FLOOR : Z_SPREAD;
      aimed_point(int'($urandom_range(0, 2 * span)) - span, reach, pick);
    end
  endtask

  task automatic run(input int count);
    repeat (count) random_item();
    send_bare(KIND_DUMP);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_regs(input int min_h, input int incline, input int max_h,
                           input int hf, input int sw, input int count);
    drain();
    write_reg(REG_MIN_HEIGHT, 24'(min_h));
    write_reg(REG_FLOOR_SLOPE, 24'(incline));
    write_reg(REG_MAX_HEIGHT, 24'(max_h));
    write_reg(REG_HALF_FOV, 24'(hf));
    write_reg(REG_SECTOR_WIDTH, 24'(sw));
    write_reg(REG_SECTOR_COUNT, 24'(count));
    cfg_we <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings
    send_bare(KIND_DUMP);
    aimed_point(0, 2560, Z_AT_FLOOR);
    aimed_point(0, 2600, Z_BELOW_FLOOR);
    aimed_point(3000, 1000, Z_AT_CEILING);
    aimed_point(-8000, 500, Z_SPREAD);
    aimed_point(8000, 700, Z_SPREAD);
    aimed_point(-9500, 500, Z_SPREAD);
    aimed_point(0, 3000, Z_SPREAD);
    aimed_point(0, 256, Z_SPREAD);
    send(KIND_POINT, 24'd0, 24'd100, 24'd500);
    send(KIND_POINT, 24'h800000, 24'h800000, 24'h800000);
    send(KIND_POINT, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send(KIND_POINT, 24'h7FFFFF, 24'd0, 24'd1000);
    send(KIND_POINT, 24'd1, 24'd0, 24'd128);
    send(KIND_SPARE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_bare(KIND_DUMP);
    send_bare(KIND_CLEAR);
    send_bare(KIND_DUMP);
    aimed_point(4000, 1200, Z_SPREAD);
    send_bare(KIND_DUMP);

    // wide open, every sector in use
    load_regs(0, 0, 8388607, 25735, 805, 64);
    send(KIND_POINT, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFE);
    send(KIND_POINT, 24'h7FFFFF, 24'h800000, 24'h000000);
    run(15);

    // zero count and width fall back to one; steep floor; no sender gaps
    idle_on = 1'b0;
    load_regs(0, 65535, 8388607, 4096, 0, 0);
    run(10);
    idle_on = 1'b1;

    // nothing passes the height tests; count above the maximum
    load_regs(8388607, 65535, -8388608, 0, 25735, 127);
    run(8);

    // few sectors, so bearings near the upper edge clamp into the last one
    load_regs(300, 20000, 3000, 12000, 333, 7);
    send_bare(KIND_CLEAR);
    aimed_point(11999, 900, Z_SPREAD);
    aimed_point(12000, 800, Z_SPREAD);
    aimed_point(-12000, 700, Z_SPREAD);
    run(10);
    drain();
    run(10);

    load_regs(50, 4000, 2000, 40, 1, 64);
    run(12);

    drain();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> polar_sector_nearest_range_top.f
src/psnr_pkg.sv
src/psnr_ram.sv
src/polar_sector_nearest_range_top.sv
bench/tb_polar_sector_nearest_range_top.sv
